// ===== hdl/nnzs_pkg.sv =====
// Shared types and constants for the nearest-neighbor zoom scaler.
// No dependencies; every other file of the block imports this package.
package nnzs_pkg;

  // Field widths.
  localparam int unsigned DIM_W    = 9;   // panel and destination coordinates
  localparam int unsigned SRC_CW   = 8;   // source frame coordinates
  localparam int unsigned ZOOM_W   = 10;  // zoom register and divider divisor
  localparam int unsigned PROD_W   = 17;  // coordinate times window size
  localparam int unsigned QUO_W    = 8;   // per-pixel quotient bits
  localparam int unsigned DIV_STG  = 4;   // pipeline stages of the pixel divider

  // Configuration port.
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 10;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam int unsigned DEF_MAX_TARGET_DIM = 512;

  // Source windows.
  localparam logic [DIM_W-1:0]  SRC_W_FULL = 9'd256;
  localparam logic [DIM_W-1:0]  SRC_H_FULL = 9'd192;
  localparam logic [DIM_W-1:0]  SRC_W_HH   = 9'd160;
  localparam logic [DIM_W-1:0]  SRC_H_HH   = 9'd144;
  localparam logic [SRC_CW-1:0] SRC_X0_HH  = 8'd48;
  localparam logic [SRC_CW-1:0] SRC_Y0_HH  = 8'd24;
  localparam logic [DIM_W-1:0]  WIN_MIN    = 9'd16;
  localparam logic [ZOOM_W-1:0] ZOOM_UNITY = 10'd100;

  // Register reset values.
  localparam logic              RST_HANDHELD = 1'b0;
  localparam logic              RST_FILL     = 1'b1;
  localparam logic [ZOOM_W-1:0] RST_ZOOM     = 10'd110;
  localparam logic [DIM_W-1:0]  RST_TGT_W    = 9'd240;
  localparam logic [DIM_W-1:0]  RST_TGT_H    = 9'd135;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_AW-1:0] {
    REG_HANDHELD = 3'd0,
    REG_FILL     = 3'd1,
    REG_ZOOM     = 3'd2,
    REG_TGT_W    = 3'd3,
    REG_TGT_H    = 3'd4
  } cfg_reg_t;

  // Picture geometry, fixed between configuration writes.
  typedef struct packed {
    logic [DIM_W-1:0]  dw;   // scaled picture width
    logic [DIM_W-1:0]  dh;   // scaled picture height
    logic [DIM_W-1:0]  ox;   // horizontal picture offset on the panel
    logic [DIM_W-1:0]  oy;   // vertical picture offset on the panel
    logic [DIM_W-1:0]  rw;   // zoom window width
    logic [DIM_W-1:0]  rh;   // zoom window height
    logic [SRC_CW-1:0] rx0;  // zoom window left column in the source frame
    logic [SRC_CW-1:0] ry0;  // zoom window top row in the source frame
  } geo_t;

endpackage

// ===== hdl/nnzs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, for the geometry setup.
// Depends on nnzs_pkg.
module nnzs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nnzs_pkg::PROD_W-1:0] dvd,
  input  logic [nnzs_pkg::ZOOM_W-1:0] dvs,
  output logic                       done,
  output logic [nnzs_pkg::PROD_W-1:0] quo
);
  import nnzs_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ZOOM_W-1:0] rem_r;
  logic [ZOOM_W-1:0] rem_nxt;
  logic [ZOOM_W-1:0] dvs_r;
  logic [PROD_W-1:0] quo_r;
  logic [PROD_W-1:0] quo_nxt;
  logic [ZOOM_W:0]   sh;
  logic              ge;

  always_comb begin
    sh      = {rem_r, quo_r[PROD_W-1]};
    ge      = (sh >= {1'b0, dvs_r});
    rem_nxt = ge ? ZOOM_W'(sh - {1'b0, dvs_r}) : sh[ZOOM_W-1:0];
    quo_nxt = {quo_r[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0) && !start;
      busy_r <= start || (busy_r && (cnt_r != '0));
    end
    if (start) begin
      rem_r <= '0;
      quo_r <= dvd;
      dvs_r <= dvs;
      cnt_r <= CNT_W'(PROD_W - 1);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/nnzs_geom.sv =====
// Configuration registers and the setup sequencer that derives the picture geometry.
// Depends on nnzs_pkg and nnzs_div.
module nnzs_geom #(
  parameter int unsigned MAX_TARGET_DIM = nnzs_pkg::DEF_MAX_TARGET_DIM
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [nnzs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [nnzs_pkg::CFG_DW-1:0] cfg_wdata,
  output nnzs_pkg::geo_t              geo,
  output logic                        geo_rdy
);
  import nnzs_pkg::*;

  typedef enum logic [2:0] {
    ST_START, ST_FIT, ST_WFIT, ST_WRW, ST_WRH, ST_DONE, ST_IDLE
  } state_t;

  state_t st_r, st_nxt;

  logic              hand_r, fill_r;
  logic [ZOOM_W-1:0] zoom_r, zp_r;
  logic [DIM_W-1:0]  tgtw_r, tgth_r, tw_r, th_r, fitq_r;
  logic              cond_r;
  logic [PROD_W-1:0] rwq_r, rhq_r;
  geo_t              geo_r, geo_nxt;

  logic [DIM_W-1:0]    src_w, src_h;
  logic [SRC_CW-1:0]   x0, y0;
  logic [2*DIM_W-1:0]  prod_tw, prod_th;
  logic                fit_cond;
  logic                div_start, div_done;
  logic [PROD_W-1:0]   div_dvd, div_quo;
  logic [ZOOM_W-1:0]   div_dvs;
  logic [DIM_W-1:0]    dw_c, dh_c, rw_c, rh_c;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    else if (32'(v) > MAX_TARGET_DIM) return DIM_W'(MAX_TARGET_DIM);
    else return v;
  endfunction

  function automatic logic [DIM_W-1:0] win_clamp(input logic [PROD_W-1:0] q,
                                                 input logic [DIM_W-1:0]  src);
    if (q < PROD_W'(WIN_MIN)) return WIN_MIN;
    else if (q > PROD_W'(src)) return src;
    else return q[DIM_W-1:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_r <= RST_HANDHELD;
      fill_r <= RST_FILL;
      zoom_r <= RST_ZOOM;
      tgtw_r <= RST_TGT_W;
      tgth_r <= RST_TGT_H;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HANDHELD: hand_r <= cfg_wdata[0];
        REG_FILL:     fill_r <= cfg_wdata[0];
        REG_ZOOM:     zoom_r <= cfg_wdata[ZOOM_W-1:0];
        REG_TGT_W:    tgtw_r <= cfg_wdata[DIM_W-1:0];
        REG_TGT_H:    tgth_r <= cfg_wdata[DIM_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    src_w    = hand_r ? SRC_W_HH  : SRC_W_FULL;
    src_h    = hand_r ? SRC_H_HH  : SRC_H_FULL;
    x0       = hand_r ? SRC_X0_HH : '0;
    y0       = hand_r ? SRC_Y0_HH : '0;
    prod_tw  = tw_r * src_h;
    prod_th  = th_r * src_w;
    fit_cond = (prod_tw < prod_th);

    // Three divisions run back to back on the shared divider.
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (st_r)
      ST_FIT: begin
        div_start = 1'b1;
        div_dvd   = fit_cond ? prod_tw[PROD_W-1:0] : prod_th[PROD_W-1:0];
        div_dvs   = fit_cond ? ZOOM_W'(src_w) : ZOOM_W'(src_h);
      end
      ST_WFIT: begin
        div_start = div_done;
        div_dvd   = PROD_W'(src_w) * PROD_W'(ZOOM_UNITY);
        div_dvs   = zp_r;
      end
      ST_WRW: begin
        div_start = div_done;
        div_dvd   = PROD_W'(src_h) * PROD_W'(ZOOM_UNITY);
        div_dvs   = zp_r;
      end
      default: ;
    endcase

    // Final geometry. With fill, the offsets come out as zero by themselves.
    dw_c = (fill_r || cond_r)  ? tw_r : fitq_r;
    dh_c = (fill_r || !cond_r) ? th_r : fitq_r;
    if (dw_c == '0) dw_c = DIM_W'(1);
    if (dh_c == '0) dh_c = DIM_W'(1);
    rw_c = win_clamp(rwq_r, src_w);
    rh_c = win_clamp(rhq_r, src_h);
    geo_nxt.dw  = dw_c;
    geo_nxt.dh  = dh_c;
    geo_nxt.ox  = DIM_W'(tw_r - dw_c) >> 1;
    geo_nxt.oy  = DIM_W'(th_r - dh_c) >> 1;
    geo_nxt.rw  = rw_c;
    geo_nxt.rh  = rh_c;
    geo_nxt.rx0 = SRC_CW'(x0 + SRC_CW'(DIM_W'(src_w - rw_c) >> 1));
    geo_nxt.ry0 = SRC_CW'(y0 + SRC_CW'(DIM_W'(src_h - rh_c) >> 1));

    if (cfg_we) begin
      st_nxt = ST_START;
    end else begin
      unique case (st_r)
        ST_START: st_nxt = ST_FIT;
        ST_FIT:   st_nxt = ST_WFIT;
        ST_WFIT:  st_nxt = div_done ? ST_WRW : ST_WFIT;
        ST_WRW:   st_nxt = div_done ? ST_WRH : ST_WRW;
        ST_WRH:   st_nxt = div_done ? ST_DONE : ST_WRH;
        ST_DONE:  st_nxt = ST_IDLE;
        ST_IDLE:  st_nxt = ST_IDLE;
        default:  st_nxt = ST_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_START;
    end else begin
      st_r <= st_nxt;
    end
    if (st_r == ST_START) begin
      tw_r <= clamp_dim(tgtw_r);
      th_r <= clamp_dim(tgth_r);
      zp_r <= (zoom_r == '0) ? ZOOM_UNITY : zoom_r;
    end
    if (st_r == ST_FIT) begin
      cond_r <= fit_cond;
    end
    if (st_r == ST_WFIT && div_done) begin
      fitq_r <= div_quo[DIM_W-1:0];
    end
    if (st_r == ST_WRW && div_done) begin
      rwq_r <= div_quo;
    end
    if (st_r == ST_WRH && div_done) begin
      rhq_r <= div_quo;
    end
    if (st_r == ST_DONE) begin
      geo_r <= geo_nxt;
    end
  end

  nnzs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign geo     = geo_r;
  assign geo_rdy = (st_r == ST_IDLE) && !cfg_we;

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !geo_rdy)
    else $error("geometry reported ready right after a configuration write");

  a_geo_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) && !cfg_we |=> $stable(geo_r))
    else $error("geometry changed while idle");

  a_dims_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (geo_r.dw != '0) && (geo_r.dh != '0))
    else $error("scaled picture dimension of zero");

  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (geo_r.rw >= WIN_MIN) && (geo_r.rw <= SRC_W_FULL)
                          && (geo_r.rh >= WIN_MIN) && (geo_r.rh <= SRC_H_FULL))
    else $error("zoom window outside its clamp range");

endmodule

// ===== hdl/nnzs_pipe.sv =====
// Per-pixel mapping pipeline: multiply stage, four two-bit divider stages, output register.
// Depends on nnzs_pkg.
module nnzs_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nnzs_pkg::geo_t               geo,
  input  logic                         in_vld,
  input  logic [nnzs_pkg::DIM_W-1:0]   in_col,
  input  logic [nnzs_pkg::DIM_W-1:0]   in_row,
  output logic                         in_rdy,
  output logic                         out_vld,
  input  logic                         out_rdy,
  output logic [nnzs_pkg::SRC_CW-1:0]  source_col,
  output logic [nnzs_pkg::SRC_CW-1:0]  source_row,
  output logic [nnzs_pkg::DIM_W-1:0]   screen_col,
  output logic [nnzs_pkg::DIM_W-1:0]   screen_row,
  output logic                         inside_res,
  output logic                         row_last
);
  import nnzs_pkg::*;

  localparam int unsigned NSTG     = DIV_STG + 1;
  localparam int unsigned BITS_PER = QUO_W / DIV_STG;

  typedef struct packed {
    logic [PROD_W-1:0] rc;    // column partial remainder
    logic [PROD_W-1:0] rr;    // row partial remainder
    logic [QUO_W-1:0]  qc;    // column quotient, bits shifted in at the bottom, MSB first
    logic [QUO_W-1:0]  qr;
    logic [DIM_W-1:0]  scol;
    logic [DIM_W-1:0]  srow;
    logic              ins;
    logic              last;
  } pix_t;

  pix_t             stg_r   [NSTG];
  pix_t             stg_nxt [NSTG];
  logic [NSTG-1:0]  vld_r;
  logic [NSTG:0]    en;
  logic [2*DIM_W-1:0] prod_c, prod_r;

  logic              out_vld_r, out_ins_r, out_last_r;
  logic [SRC_CW-1:0] out_scol_r, out_srow_r;
  logic [DIM_W-1:0]  out_dcol_r, out_drow_r;

  // Two restoring steps on both coordinates; quotient bits come MSB first.
  function automatic pix_t div_stage(input pix_t p, input logic [DIM_W-1:0] dw,
                                     input logic [DIM_W-1:0] dh, input int hb);
    pix_t          o;
    logic [PROD_W:0] dsh;
    logic          bc;
    o = p;
    for (int b = 0; b < BITS_PER; b++) begin
      dsh = {{(PROD_W+1-DIM_W){1'b0}}, dw} << (hb - b);
      bc  = ({1'b0, o.rc} >= dsh);
      if (bc) o.rc = PROD_W'({1'b0, o.rc} - dsh);
      o.qc = {o.qc[QUO_W-2:0], bc};
      dsh = {{(PROD_W+1-DIM_W){1'b0}}, dh} << (hb - b);
      bc  = ({1'b0, o.rr} >= dsh);
      if (bc) o.rr = PROD_W'({1'b0, o.rr} - dsh);
      o.qr = {o.qr[QUO_W-2:0], bc};
    end
    return o;
  endfunction

  always_comb begin
    en[NSTG] = !out_vld_r || out_rdy;
    for (int j = NSTG - 1; j >= 0; j--) begin
      en[j] = !vld_r[j] || en[j+1];
    end

    prod_c = in_col * geo.rw;
    prod_r = in_row * geo.rh;
    stg_nxt[0].rc   = prod_c[PROD_W-1:0];
    stg_nxt[0].rr   = prod_r[PROD_W-1:0];
    stg_nxt[0].qc   = '0;
    stg_nxt[0].qr   = '0;
    stg_nxt[0].scol = DIM_W'(geo.ox + in_col);
    stg_nxt[0].srow = DIM_W'(geo.oy + in_row);
    stg_nxt[0].ins  = (in_col < geo.dw) && (in_row < geo.dh);
    stg_nxt[0].last = (in_col == DIM_W'(geo.dw - 1'b1));
    for (int j = 1; j < NSTG; j++) begin
      stg_nxt[j] = div_stage(stg_r[j-1], geo.dw, geo.dh, QUO_W - 1 - (j - 1) * BITS_PER);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (en[0]) vld_r[0] <= in_vld;
      for (int j = 1; j < NSTG; j++) begin
        if (en[j]) vld_r[j] <= vld_r[j-1];
      end
      if (en[NSTG]) out_vld_r <= vld_r[NSTG-1];
    end
    for (int j = 0; j < NSTG; j++) begin
      if (en[j]) stg_r[j] <= stg_nxt[j];
    end
    if (en[NSTG]) begin
      // Pixels outside the picture read as all zeros.
      out_ins_r  <= stg_r[NSTG-1].ins;
      out_last_r <= stg_r[NSTG-1].ins && stg_r[NSTG-1].last;
      out_scol_r <= stg_r[NSTG-1].ins ? SRC_CW'(geo.rx0 + stg_r[NSTG-1].qc) : '0;
      out_srow_r <= stg_r[NSTG-1].ins ? SRC_CW'(geo.ry0 + stg_r[NSTG-1].qr) : '0;
      out_dcol_r <= stg_r[NSTG-1].ins ? stg_r[NSTG-1].scol : '0;
      out_drow_r <= stg_r[NSTG-1].ins ? stg_r[NSTG-1].srow : '0;
    end
  end

  assign in_rdy     = en[0];
  assign out_vld    = out_vld_r;
  assign source_col = out_scol_r;
  assign source_row = out_srow_r;
  assign screen_col = out_dcol_r;
  assign screen_row = out_drow_r;
  assign inside_res = out_ins_r;
  assign row_last   = out_last_r;

  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ins_r |-> (out_scol_r == '0) && (out_srow_r == '0)
                                && (out_dcol_r == '0) && (out_drow_r == '0) && !out_last_r)
    else $error("result outside the picture carries nonzero fields");

  a_last_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_last_r |-> out_ins_r)
    else $error("row end flagged outside the picture");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && out_vld_r && !out_rdy |-> !in_rdy)
    else $error("full pipeline accepted a pixel while the output was stalled");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ({1'b0, out_srow_r} < SRC_H_FULL))
    else $error("source row beyond the source frame");

endmodule

// ===== hdl/nearest_neighbor_zoom_scaler_top.sv =====
// Top level of the nearest-neighbor zoom scaler: stream ports and payload packing.
// Depends on nnzs_pkg, nnzs_geom (with nnzs_div) and nnzs_pipe.
//
// Usage: each input transfer carries one destination pixel coordinate; each
// output transfer returns the source frame pixel to read for it, the panel
// position of the pixel and two flags. Exactly one output transfer follows
// every input transfer, in order.
// Each pixel passes through six register stages: one multiply stage, four
// divider stages that resolve two quotient bits each, and the output register;
// the first stage captures the pixel at the transfer edge itself. Throughput
// is one pixel per cycle while out_tready stays high, set by the fully
// pipelined per-pixel divider.
// After reset and after every configuration write, a setup sequencer derives
// the picture geometry with one shared bit-serial divider (three divisions
// of 17 quotient steps each, run back to back); in_tready stays low until it
// finishes.
// The user must write configuration only while the block is idle; the block
// itself does not enforce it. When the receiver stalls, results back up stage
// by stage; empty stages keep taking new pixels until the pipeline is full.
module nearest_neighbor_zoom_scaler_top #(
  parameter int unsigned MAX_TARGET_DIM = nnzs_pkg::DEF_MAX_TARGET_DIM
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [nnzs_pkg::IN_TDATA_W-1:0]  in_tdata,   // dest_col, dest_row
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [nnzs_pkg::OUT_TDATA_W-1:0] out_tdata,  // source_col, source_row,
                                                       // screen_col, screen_row
  output logic                             out_tuser,  // inside_res
  output logic                             out_tlast,  // row_last
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [nnzs_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [nnzs_pkg::CFG_DW-1:0]      cfg_wdata
);
  import nnzs_pkg::*;

  geo_t              geo;
  logic              geo_rdy;
  logic              pipe_rdy;
  logic [DIM_W-1:0]  dest_col, dest_row;
  logic [SRC_CW-1:0] source_col, source_row;
  logic [DIM_W-1:0]  screen_col, screen_row;

  assign dest_col = in_tdata[DIM_W-1:0];
  assign dest_row = in_tdata[2*DIM_W-1:DIM_W];

  nnzs_geom #(
    .MAX_TARGET_DIM (MAX_TARGET_DIM)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .geo       (geo),
    .geo_rdy   (geo_rdy)
  );

  // Pixels are only taken once the geometry is settled.
  nnzs_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .geo        (geo),
    .in_vld     (in_tvalid && geo_rdy),
    .in_col     (dest_col),
    .in_row     (dest_row),
    .in_rdy     (pipe_rdy),
    .out_vld    (out_tvalid),
    .out_rdy    (out_tready),
    .source_col (source_col),
    .source_row (source_row),
    .screen_col (screen_col),
    .screen_row (screen_row),
    .inside_res (out_tuser),
    .row_last   (out_tlast)
  );

  assign in_tready = pipe_rdy && geo_rdy;
  assign out_tdata = {(OUT_TDATA_W - 2*SRC_CW - 2*DIM_W)'(0),
                      screen_row, screen_col, source_row, source_col};

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the nearest-neighbor zoom scaler top level.
// Depends on nnzs_pkg and nearest_neighbor_zoom_scaler_top; predicts each result
// from its own copy of the registers and checks the output stream in order.
`timescale 1ns / 100ps

module tb;
  import nnzs_pkg::*;

  typedef struct {
    logic [SRC_CW-1:0] source_col;
    logic [SRC_CW-1:0] source_row;
    logic [DIM_W-1:0]  screen_col;
    logic [DIM_W-1:0]  screen_row;
    logic              inside_res;
    logic              row_last;
  } scaled_pixel_t;

  // Register shadow, picture geometry and the queue of pixels still owed by the block.
  class zoom_scoreboard;
    bit          handheld;
    bit          fill;
    int unsigned zoom;
    int unsigned tgt_w;
    int unsigned tgt_h;

    // Geometry derived from the registers.
    int unsigned pic_w, pic_h, off_x, off_y;
    int unsigned win_w, win_h, win_x0, win_y0;

    scaled_pixel_t expected_pixels[$];
    int unsigned   mismatches;

    function new();
      handheld   = RST_HANDHELD;
      fill       = RST_FILL;
      zoom       = 32'(RST_ZOOM);
      tgt_w      = 32'(RST_TGT_W);
      tgt_h      = 32'(RST_TGT_H);
      mismatches = 0;
      update_geometry();
    endfunction

    function int unsigned window_span(int unsigned src, int unsigned zp);
      int unsigned w;
      w = src * 100 / zp;
      if (w < 32'(WIN_MIN)) w = 32'(WIN_MIN);
      if (w > src) w = src;
      return w;
    endfunction

    function void update_geometry();
      int unsigned sw, sh, tw, th, zp;
      sw = handheld ? 32'(SRC_W_HH) : 32'(SRC_W_FULL);
      sh = handheld ? 32'(SRC_H_HH) : 32'(SRC_H_FULL);
      // A zero panel size counts as one pixel; the 9-bit registers never exceed the cap.
      tw = (tgt_w == 0) ? 1 : tgt_w;
      th = (tgt_h == 0) ? 1 : tgt_h;
      if (tw > DEF_MAX_TARGET_DIM) tw = DEF_MAX_TARGET_DIM;
      if (th > DEF_MAX_TARGET_DIM) th = DEF_MAX_TARGET_DIM;
      if (fill) begin
        pic_w = tw;
        pic_h = th;
        off_x = 0;
        off_y = 0;
      end else begin
        // Keep aspect: the narrower ratio wins, ties go to the vertical fit.
        if (tw * sh < th * sw) begin
          pic_w = tw;
          pic_h = sh * tw / sw;
        end else begin
          pic_w = sw * th / sh;
          pic_h = th;
        end
        if (pic_w < 1) pic_w = 1;
        if (pic_h < 1) pic_h = 1;
        off_x = (tw - pic_w) / 2;
        off_y = (th - pic_h) / 2;
      end
      zp     = (zoom == 0) ? 32'(ZOOM_UNITY) : zoom;
      win_w  = window_span(sw, zp);
      win_h  = window_span(sh, zp);
      win_x0 = (handheld ? 32'(SRC_X0_HH) : 0) + (sw - win_w) / 2;
      win_y0 = (handheld ? 32'(SRC_Y0_HH) : 0) + (sh - win_h) / 2;
    endfunction

    // Mirrors a configuration write; unknown indexes change nothing.
    function void set_reg(logic [CFG_AW-1:0] index, logic [CFG_DW-1:0] value);
      case (index)
        REG_HANDHELD: handheld = value[0];
        REG_FILL:     fill     = value[0];
        REG_ZOOM:     zoom     = 32'(value);
        REG_TGT_W:    tgt_w    = 32'(value[DIM_W-1:0]);
        REG_TGT_H:    tgt_h    = 32'(value[DIM_W-1:0]);
        default: ;
      endcase
      update_geometry();
    endfunction

    function void note_pixel(logic [DIM_W-1:0] col, logic [DIM_W-1:0] row);
      scaled_pixel_t px;
      px = '{default: '0};
      if (32'(col) < pic_w && 32'(row) < pic_h) begin
        px.source_col = SRC_CW'(win_x0 + 32'(col) * win_w / pic_w);
        px.source_row = SRC_CW'(win_y0 + 32'(row) * win_h / pic_h);
        px.screen_col = DIM_W'(off_x + 32'(col));
        px.screen_row = DIM_W'(off_y + 32'(row));
        px.inside_res = 1'b1;
        px.row_last   = (32'(col) == pic_w - 1);
      end
      expected_pixels.push_back(px);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(scaled_pixel_t got);
      scaled_pixel_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual col %0d row %0d inside %0d",
                 $time, got.source_col, got.source_row, got.inside_res);
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("source_col", 32'(want.source_col), 32'(got.source_col));
      compare_field("source_row", 32'(want.source_row), 32'(got.source_row));
      compare_field("screen_col", 32'(want.screen_col), 32'(got.screen_col));
      compare_field("screen_row", 32'(want.screen_row), 32'(got.screen_row));
      compare_field("inside_res", 32'(want.inside_res), 32'(got.inside_res));
      compare_field("row_last", 32'(want.row_last), 32'(got.row_last));
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  // The run is short; this bound only catches a hang.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // An index past the register list; writes to it must be ignored.
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;

  // While set, neither side inserts idle cycles.
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;

  zoom_scoreboard scoreboard = new();

  nearest_neighbor_zoom_scaler_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: values are sampled at the edge, before this edge's updates land,
  // so a transfer is exactly an edge with tvalid and tready both high.
  always @(posedge clk) begin
    scaled_pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.source_col = out_tdata[7:0];
      got.source_row = out_tdata[15:8];
      got.screen_col = out_tdata[24:16];
      got.screen_row = out_tdata[33:25];
      got.inside_res = out_tuser;
      got.row_last   = out_tlast;
      scoreboard.check_result(got);
    end
    out_tready <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one coordinate and returns at the edge where the transfer happens.
  // tvalid is left high so a following pixel can go out back to back.
  task automatic send_pixel(input logic [DIM_W-1:0] col, input logic [DIM_W-1:0] row);
    if (!calm && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - 2 * DIM_W){1'b0}}, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scoreboard.note_pixel(col, row);
  endtask

  // The sender stops until the block has returned every pixel it took.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending() != 0) @(posedge clk);
  endtask

  // One write, after which the enable goes low again.
  task automatic write_reg(input logic [CFG_AW-1:0] index, input logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    scoreboard.set_reg(index, value);
    @(posedge clk);
  endtask

  // Rewrites every register once the block is idle. Upper bits of the one-bit
  // registers carry noise, and a stray write to an unused index is mixed in.
  task automatic apply_setting(input bit hh, input bit fit, input int unsigned zoom,
                               input int unsigned tw, input int unsigned th);
    hold_until_drained();
    write_reg(REG_HANDHELD, {(CFG_DW-1)'($urandom_range(511)), hh});
    write_reg(REG_UNUSED, CFG_DW'($urandom_range(1023)));
    write_reg(REG_FILL, {(CFG_DW-1)'($urandom_range(511)), fit});
    write_reg(REG_ZOOM, CFG_DW'(zoom));
    write_reg(REG_TGT_W, CFG_DW'(tw));
    write_reg(REG_TGT_H, CFG_DW'(th));
  endtask

  // Two opposite picture corners, the first pixels just outside it, and the largest coordinate.
  task automatic corner_pixels();
    logic [DIM_W-1:0] last_col, last_row;
    last_col = DIM_W'(scoreboard.pic_w - 1);
    last_row = DIM_W'(scoreboard.pic_h - 1);
    send_pixel('0, '0);
    send_pixel(last_col, last_row);
    send_pixel(DIM_W'(scoreboard.pic_w), last_row);
    send_pixel(last_col, DIM_W'(scoreboard.pic_h));
    send_pixel('1, '1);
  endtask

  // Mostly pixels inside the picture, a share on its last column, the rest anywhere.
  // Halfway through, the sender waits for the pipeline to empty.
  task automatic random_pixels(input int unsigned count);
    int unsigned pick;
    logic [DIM_W-1:0] col, row;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      row  = DIM_W'($urandom_range(scoreboard.pic_h - 1));
      if (pick < 60) begin
        col = DIM_W'($urandom_range(scoreboard.pic_w - 1));
      end else if (pick < 75) begin
        col = DIM_W'(scoreboard.pic_w - 1);
      end else begin
        col = DIM_W'($urandom_range(511));
        row = DIM_W'($urandom_range(511));
      end
      send_pixel(col, row);
      if (i == count / 2) hold_until_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reset values first, then settings at the edges of the ranges.
    corner_pixels();
    apply_setting(1'b1, 1'b0, 0, 240, 135);     // zero zoom, aspect kept, handheld
    corner_pixels();
    apply_setting(1'b0, 1'b0, 1023, 511, 511);  // largest zoom and panel
    corner_pixels();
    apply_setting(1'b1, 1'b1, 1, 1, 1);         // one-pixel panel, window at full size
    corner_pixels();
    apply_setting(1'b0, 1'b0, 100, 0, 511);     // zero width, picture shrinks to 1x1
    corner_pixels();

    // Random part.
    apply_setting(1'b1, 1'b0, 1000, 511, 1);    // one row high
    random_pixels(40);
    apply_setting(1'b0, 1'b0, 150, 256, 192);   // equal fit ratios
    random_pixels(60);
    apply_setting(1'b0, 1'b1, 500, 511, 511);
    calm = 1'b1;                                 // a long stretch with no idling at all
    random_pixels(80);
    hold_until_drained();
    calm = 1'b0;
    apply_setting(1'b1, 1'b0, 110, 320, 240);
    random_pixels(60);
    apply_setting(1'b0, 1'b1, 110, 240, 135);
    random_pixels(60);
    for (int unsigned p = 0; p < 5; p++) begin
      apply_setting(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(1023),
                    $urandom_range(511), $urandom_range(511));
      random_pixels(40);
    end

    hold_until_drained();
    repeat (16) @(posedge clk);
    if (scoreboard.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/nnzs_pkg.sv
hdl/nnzs_div.sv
hdl/nnzs_geom.sv
hdl/nnzs_pipe.sv
hdl/nearest_neighbor_zoom_scaler_top.sv
tb/tb.sv
